// File: sv/dcpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcpm_pkg
// Shared widths, register map, reset values and config bundle for the
// two-channel PID speed controller.
// ----------------------------------------------------------------------------
package dcpm_pkg;

  localparam int NUM_CHANNELS_DEF   = 2;
  localparam int SPEED_WIDTH_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int ERR_SUM_W = 16;   // holds +/- a LIMIT_W magnitude
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST       = 16'd6400;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST      = 16'd384;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST      = 16'd77;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST  = 15'd500;
  localparam logic [LIMIT_W-1:0] MIN_START_DRIVE_RST = 15'd2000;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST     = 15'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEG_GAIN      = 3'd1,
    REG_DERIV_GAIN      = 3'd2,
    REG_INTEGRAL_LIMIT  = 3'd3,
    REG_MIN_START_DRIVE = 3'd4,
    REG_DRIVE_LIMIT     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] min_start_drive;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

endpackage
`default_nettype wire

// File: sv/dcpm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcpm_front
// Error, clamped integrator and previous-error state per channel; registers
// the three gain products.
// ----------------------------------------------------------------------------
module dcpm_front #(
  parameter int NUM_CHANNELS = dcpm_pkg::NUM_CHANNELS_DEF,
  parameter int SPEED_WIDTH  = dcpm_pkg::SPEED_WIDTH_DEF,
  parameter int CH_W         = 1,
  parameter int PROD_W       = SPEED_WIDTH + 19
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             adv,      // a beat moves into this stage
  input  wire        [CH_W-1:0]           ch,
  input  wire signed [SPEED_WIDTH-1:0]    meas,
  input  wire signed [SPEED_WIDTH-1:0]    targ,
  input  wire dcpm_pkg::cfg_t             cfg,
  output logic signed [PROD_W-1:0]        prop_r,
  output logic signed [PROD_W-1:0]        integ_r,
  output logic signed [PROD_W-1:0]        deriv_r,
  output logic                            targ_nz_r
);
  import dcpm_pkg::*;

  localparam int ERR_W = SPEED_WIDTH + 1;
  localparam int SUM_W = ((ERR_W > ERR_SUM_W) ? ERR_W : ERR_SUM_W) + 1;

  logic signed [ERR_SUM_W-1:0] es_r [NUM_CHANNELS];
  logic signed [ERR_W-1:0]     pe_r [NUM_CHANNELS];

  logic signed [ERR_W-1:0]     err;
  logic signed [ERR_W:0]       diff;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     lim;
  logic signed [ERR_SUM_W-1:0] es_nxt;
  logic signed [PROD_W-1:0]    prop_nxt;
  logic signed [PROD_W-1:0]    integ_nxt;
  logic signed [PROD_W-1:0]    deriv_nxt;

  always_comb begin
    err  = ERR_W'(targ) - ERR_W'(meas);
    diff = (ERR_W+1)'(err) - (ERR_W+1)'(pe_r[ch]);
    sum  = SUM_W'(es_r[ch]) + SUM_W'(err);
    lim  = $signed(SUM_W'(cfg.integral_limit));
    if (sum > lim) begin
      es_nxt = ERR_SUM_W'(lim);
    end else if (sum < -lim) begin
      es_nxt = ERR_SUM_W'(-lim);
    end else begin
      es_nxt = ERR_SUM_W'(sum);
    end
    prop_nxt  = PROD_W'($signed({1'b0, cfg.prop_gain}))  * PROD_W'(err);
    integ_nxt = PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'(es_nxt);
    deriv_nxt = PROD_W'($signed({1'b0, cfg.deriv_gain})) * PROD_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        es_r[i] <= '0;
        pe_r[i] <= '0;
      end
    end else if (adv) begin
      es_r[ch] <= es_nxt;
      pe_r[ch] <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prop_r    <= prop_nxt;
      integ_r   <= integ_nxt;
      deriv_r   <= deriv_nxt;
      targ_nz_r <= (targ != '0);
    end
  end

endmodule
`default_nettype wire

// File: sv/dcpm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcpm_back
// Sums the products, truncates toward zero, applies start boost and output
// saturation into the result register.
// ----------------------------------------------------------------------------
module dcpm_back #(
  parameter int GAIN_FRAC_BITS = dcpm_pkg::GAIN_FRAC_BITS_DEF,
  parameter int PROD_W         = dcpm_pkg::SPEED_WIDTH_DEF + 19
) (
  input  wire                             clk,
  input  wire                             adv,
  input  wire signed [PROD_W-1:0]         prop,
  input  wire signed [PROD_W-1:0]         integ,
  input  wire signed [PROD_W-1:0]         deriv,
  input  wire                             targ_nz,
  input  wire dcpm_pkg::cfg_t             cfg,
  output logic signed [dcpm_pkg::DRIVE_W-1:0] drive_r
);
  import dcpm_pkg::*;

  localparam int ACC_W = PROD_W + 2;
  localparam logic [ACC_W-1:0] BIAS =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] y;
  logic signed [ACC_W-1:0] yb;
  logic signed [ACC_W-1:0] mind;
  logic signed [ACC_W-1:0] dlim;
  logic signed [ACC_W-1:0] ys;

  always_comb begin
    acc  = ACC_W'(prop) + ACC_W'(integ) + ACC_W'(deriv);
    // bias negatives so the arithmetic shift rounds toward zero
    y    = (acc + (acc[ACC_W-1] ? $signed(BIAS) : $signed(ACC_W'(0)))) >>> GAIN_FRAC_BITS;
    mind = $signed(ACC_W'(cfg.min_start_drive));
    dlim = $signed(ACC_W'(cfg.drive_limit));
    yb   = y;
    if (targ_nz) begin
      if (y > 0 && y < mind) begin
        yb = mind;
      end else if (y < 0 && y > -mind) begin
        yb = -mind;
      end
    end
    if (yb > dlim) begin
      ys = dlim;
    end else if (yb < -dlim) begin
      ys = -dlim;
    end else begin
      ys = yb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r <= DRIVE_W'(ys);
    end
  end

endmodule
`default_nettype wire

// File: sv/dual_channel_pid_motor_speed.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_pid_motor_speed
// Positional PID speed loop for up to two motor channels (in_channel is one
// bit) with integral clamp, start-drive boost and drive saturation; gains and limits are shared.
// ----------------------------------------------------------------------------
// Pipeline: input reg, product reg and result reg from input beat to
// out_valid. Throughput: one beat per cycle while out_stall allows, also
// back to back on the same channel, since channel state is updated as the
// beat enters the product reg. Reset: config returns to defaults, all
// channel state clears to zero and the pipeline empties.
module dual_channel_pid_motor_speed #(
  parameter int NUM_CHANNELS   = dcpm_pkg::NUM_CHANNELS_DEF,
  parameter int SPEED_WIDTH    = dcpm_pkg::SPEED_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = dcpm_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_channel,
  input  wire signed [SPEED_WIDTH-1:0]         in_measured_speed,
  input  wire signed [SPEED_WIDTH-1:0]         in_target_speed,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [dcpm_pkg::DRIVE_W-1:0]  out_drive,
  input  wire                                  cfg_we,
  input  wire        [dcpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [dcpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dcpm_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // widest multiplicand is the error difference or the integrator, times a
  // sign-padded gain
  localparam int PROD_W =
    ((SPEED_WIDTH + 2 > ERR_SUM_W) ? SPEED_WIDTH + 2 : ERR_SUM_W) + GAIN_W + 1;

  cfg_t cfg_r;

  logic                          v0_r, v1_r, v2_r;
  logic                          en0, en1, en2;
  logic [CH_W-1:0]               ch0_r;
  logic signed [SPEED_WIDTH-1:0] meas0_r, targ0_r;
  logic signed [PROD_W-1:0]      prop1, integ1, deriv1;
  logic                          targ_nz1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= PROP_GAIN_RST;
      cfg_r.integ_gain      <= INTEG_GAIN_RST;
      cfg_r.deriv_gain      <= DERIV_GAIN_RST;
      cfg_r.integral_limit  <= INTEGRAL_LIMIT_RST;
      cfg_r.min_start_drive <= MIN_START_DRIVE_RST;
      cfg_r.drive_limit     <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:       cfg_r.prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:      cfg_r.integ_gain      <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:      cfg_r.deriv_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT:  cfg_r.integral_limit  <= cfg_data[LIMIT_W-1:0];
        REG_MIN_START_DRIVE: cfg_r.min_start_drive <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_LIMIT:     cfg_r.drive_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its beat moves on
  assign en2      = !v2_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      ch0_r   <= (NUM_CHANNELS > 1) ? CH_W'(in_channel) : '0;
      meas0_r <= in_measured_speed;
      targ0_r <= in_target_speed;
    end
  end

  dcpm_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SPEED_WIDTH  (SPEED_WIDTH),
    .CH_W         (CH_W),
    .PROD_W       (PROD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (en1 && v0_r),
    .ch        (ch0_r),
    .meas      (meas0_r),
    .targ      (targ0_r),
    .cfg       (cfg_r),
    .prop_r    (prop1),
    .integ_r   (integ1),
    .deriv_r   (deriv1),
    .targ_nz_r (targ_nz1)
  );

  dcpm_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .PROD_W         (PROD_W)
  ) u_back (
    .clk     (clk),
    .adv     (en2 && v1_r),
    .prop    (prop1),
    .integ   (integ1),
    .deriv   (deriv1),
    .targ_nz (targ_nz1),
    .cfg     (cfg_r),
    .drive_r (out_drive)
  );

  assign out_valid = v2_r;

  // stall only with a beat parked in the input register
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r)
    else $error("input stalled with empty input register");

  // a delivered result with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v1_r) |=> !out_valid)
    else $error("result repeated after delivery");

  // drive stays inside the saturation limit
  a_drive_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_drive) <= $signed({1'b0, cfg_r.drive_limit}) &&
                   $signed(out_drive) >= -$signed({1'b0, cfg_r.drive_limit})))
    else $error("drive outside limit");

endmodule
`default_nettype wire
